FILE: rtl/owbm_pkg.sv
// owbm_pkg: shared types and constants of the one-wire bus master
// no dependencies; imported by every module of the block

package owbm_pkg;

    // command codes on the request channel
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_RESET  = 3'd1;
    localparam logic [2:0] CMD_WBIT   = 3'd2;
    localparam logic [2:0] CMD_RBIT   = 3'd3;
    localparam logic [2:0] CMD_WBYTE  = 3'd4;
    localparam logic [2:0] CMD_RBYTE  = 3'd5;
    localparam logic [2:0] CMD_SELECT = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_RESET_RELEASE = 3'd1;
    localparam logic [2:0] CFG_WAIT_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_WRITE_ONE     = 3'd3;
    localparam logic [2:0] CFG_WRITE_ZERO    = 3'd4;
    localparam logic [2:0] CFG_READ_LOW      = 3'd5;
    localparam logic [2:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] CFG_SLOT          = 3'd7;

    // match rom command byte sent ahead of the address
    localparam logic [7:0] MATCH_ROM = 8'h55;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] reset_release_time;
        logic [7:0] wait_high_limit;
        logic [6:0] write_one_low_time;
        logic [6:0] write_zero_low_time;
        logic [6:0] read_low_time;
        logic [6:0] read_sample_delay;
        logic [6:0] slot_time;
    } t_cfg;

    // one classified microsecond request, address carried at a fixed 64-bit width
    typedef struct packed {
        logic        is_cmd;
        logic [2:0]  op;
        logic [7:0]  data_byte;
        logic [63:0] rom_address;
        logic        line_level;
    } t_item;

endpackage

FILE: rtl/owbm_front.sv
// owbm_front: input register stage that takes requests and classifies them
// depends on owbm_pkg

module owbm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic [63:0]        i_rom_address,
    input  logic               i_line_level,
    output logic               o_push,
    output owbm_pkg::t_item    o_item,
    input  logic               i_q_full
);
    import owbm_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_take;

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign w_take  = i_valid && o_ready;
    assign o_item  = r_item;

    // commands one to six start a sequence, anything else is a plain tick
    always_comb begin
        n_item.is_cmd      = (i_cmd >= CMD_RESET) && (i_cmd <= CMD_SELECT);
        n_item.op          = i_cmd;
        n_item.data_byte   = i_data_byte;
        n_item.rom_address = i_rom_address;
        n_item.line_level  = i_line_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/owbm_queue.sv
// owbm_queue: short first-in first-out queue between front and back
// depends on owbm_pkg

module owbm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  owbm_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output owbm_pkg::t_item o_item
);
    import owbm_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        ptr_next = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (w_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: rtl/owbm_engine.sv
// owbm_engine: bus sequencer that runs one microsecond per request and
// holds the result register; depends on owbm_pkg

module owbm_engine #(
    parameter int ADDRESS_BYTES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  owbm_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  owbm_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_drive_low,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic [7:0]      o_read_result,
    output logic            o_timed_out,
    output logic            o_rejected
);
    import owbm_pkg::*;

    localparam int AddrW = 8 * ADDRESS_BYTES;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_WAIT = 3'd1;
    localparam logic [2:0] PH_RST_LOW  = 3'd2;
    localparam logic [2:0] PH_RST_REL  = 3'd3;
    localparam logic [2:0] PH_SLOT     = 3'd4;

    logic [2:0]       r_phase,  n_phase;
    logic [2:0]       r_op,     n_op;
    logic [9:0]       r_mc,     n_mc;
    logic [7:0]       r_retry,  n_retry;
    logic [2:0]       r_bit,    n_bit;
    logic [3:0]       r_byte,   n_byte;
    logic [7:0]       r_shift,  n_shift;
    logic [AddrW-1:0] r_addr,   n_addr;
    logic [7:0]       r_rhold,  n_rhold;

    logic             w_fire;
    logic             w_drv, w_done, w_tmo, w_rej;
    logic             w_reads, w_last;
    logic [6:0]       w_low;
    logic [7:0]       w_target;

    logic             r_out_valid;
    logic             r_drv, r_busy, r_done, r_tmo, r_rej;

    assign w_fire = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop  = w_fire;

    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_mc    = r_mc;
        n_retry = r_retry;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_addr  = r_addr;
        n_rhold = r_rhold;
        w_drv   = 1'b0;
        w_done  = 1'b0;
        w_tmo   = 1'b0;
        w_rej   = 1'b0;
        w_reads = 1'b0;
        w_last  = 1'b0;
        w_low   = '0;
        w_target = {1'b0, i_cfg.read_low_time} + {1'b0, i_cfg.read_sample_delay};

        // command start, the same request is the first microsecond
        if (i_item.is_cmd) begin
            if (r_phase != PH_IDLE) begin
                w_rej = 1'b1;
            end else begin
                n_op    = i_item.op;
                n_mc    = '0;
                n_retry = '0;
                n_bit   = '0;
                n_byte  = '0;
                if (i_item.op == CMD_RESET) begin
                    n_phase = PH_RST_WAIT;
                end else begin
                    n_phase = PH_SLOT;
                    priority if (i_item.op == CMD_WBIT) begin
                        n_shift = {7'b0, i_item.data_byte[0]};
                    end else if (i_item.op == CMD_WBYTE) begin
                        n_shift = i_item.data_byte;
                    end else if (i_item.op == CMD_SELECT) begin
                        n_shift = MATCH_ROM;
                        n_addr  = i_item.rom_address[AddrW-1:0];
                    end else begin
                        n_shift = '0;
                    end
                end
            end
        end

        w_reads = (n_op == CMD_RBIT) || (n_op == CMD_RBYTE);

        unique case (n_phase)
            PH_IDLE: begin
            end
            PH_RST_WAIT: begin
                // bus checked at the end of every 2 us
                if (n_mc >= 10'd1) begin
                    n_mc    = '0;
                    n_retry = n_retry + 1'b1;
                    if (i_item.line_level && (n_retry < i_cfg.wait_high_limit)) begin
                        n_phase = PH_RST_LOW;
                    end else if (n_retry >= i_cfg.wait_high_limit) begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                        w_tmo   = 1'b1;
                    end
                end else begin
                    n_mc = n_mc + 1'b1;
                end
            end
            PH_RST_LOW: begin
                w_drv = 1'b1;
                if ((11'(n_mc) + 11'd1) >= 11'(i_cfg.reset_low_time)) begin
                    n_mc    = '0;
                    n_phase = PH_RST_REL;
                end else begin
                    n_mc = n_mc + 1'b1;
                end
            end
            PH_RST_REL: begin
                if ((11'(n_mc) + 11'd1) >= 11'(i_cfg.reset_release_time)) begin
                    n_mc    = '0;
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end else begin
                    n_mc = n_mc + 1'b1;
                end
            end
            PH_SLOT: begin
                w_last = (11'(n_mc) + 11'd1) >= 11'(i_cfg.slot_time);
                w_low  = w_reads ? i_cfg.read_low_time :
                         (n_shift[0] ? i_cfg.write_one_low_time : i_cfg.write_zero_low_time);
                w_drv  = n_mc < 10'(w_low);
                // sample point, pulled in to the last microsecond when late
                if (w_reads && ((n_mc == 10'(w_target)) ||
                                (w_last && (10'(w_target) > n_mc)))) begin
                    n_shift = {i_item.line_level, n_shift[7:1]};
                end
                if (w_last) begin
                    n_mc = '0;
                    if (!w_reads) begin
                        n_shift = n_shift >> 1;
                    end
                    if ((n_op == CMD_WBIT) || (n_op == CMD_RBIT)) begin
                        if (n_op == CMD_RBIT) begin
                            n_rhold = {7'b0, n_shift[7]};
                        end
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end else begin
                        n_bit = n_bit + 1'b1;
                        if (n_bit == 3'd0) begin
                            n_byte = n_byte + 1'b1;
                            if ((n_op == CMD_SELECT) && (n_byte >= 4'd1) &&
                                (n_byte <= 4'(ADDRESS_BYTES))) begin
                                // next address byte, low byte first
                                n_shift = n_addr[7:0];
                                n_addr  = n_addr >> 8;
                            end else begin
                                if (n_op == CMD_RBYTE) begin
                                    n_rhold = n_shift;
                                end
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end
                        end
                    end
                end else begin
                    n_mc = n_mc + 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_op        <= CMD_TICK;
            r_mc        <= '0;
            r_retry     <= '0;
            r_bit       <= '0;
            r_byte      <= '0;
            r_shift     <= '0;
            r_addr      <= '0;
            r_rhold     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_op    <= n_op;
                r_mc    <= n_mc;
                r_retry <= n_retry;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
                r_shift <= n_shift;
                r_addr  <= n_addr;
                r_rhold <= n_rhold;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_drv  <= w_drv;
            r_busy <= (n_phase != PH_IDLE);
            r_done <= w_done;
            r_tmo  <= w_tmo;
            r_rej  <= w_rej;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive_low   = r_drv;
    assign o_busy_res    = r_busy;
    assign o_done_res    = r_done;
    assign o_read_result = r_rhold;
    assign o_timed_out   = r_tmo;
    assign o_rejected    = r_rej;

endmodule

FILE: rtl/one_wire_bus_master_top.sv
// one_wire_bus_master_top: top level of the one-wire bus master
// depends on owbm_pkg, owbm_front, owbm_queue and owbm_engine

// Every request on the input channel is one microsecond of bus time: a
// plain tick or one of the commands reset, write bit, read bit, write byte,
// read byte and select. Each request yields exactly one result that tells
// whether the master pulls the bus low in that microsecond, whether a
// sequence is still running, whether one just finished (with timeout flag
// for a reset that never saw the bus high), the last bit or byte read, and
// whether a command was refused because the master was busy. The block
// sustains one request per clock while the receiver takes results; an
// accepted request lands in the front register, moves into the queue and
// passes the combinational sequencer step into the result register.
// A stalled receiver fills the result register, the two queue entries and
// the front register before the request channel stalls. The user writes
// timing registers on the configuration port only while the block is idle;
// the block does not enforce it. They take effect for the next request.

module one_wire_bus_master_top #(
    parameter int ADDRESS_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_cmd,
    input  logic [7:0]                 i_data_byte,
    input  logic [8*ADDRESS_BYTES-1:0] i_rom_address,
    input  logic                       i_line_level,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_drive_low,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [7:0]                 o_read_result,
    output logic                       o_timed_out,
    output logic                       o_rejected,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [9:0]                 i_cfg_data
);
    import owbm_pkg::*;

    t_cfg        r_cfg;
    t_item       w_front_item;
    t_item       w_q_item;
    logic        w_push;
    logic        w_q_full;
    logic        w_q_valid;
    logic        w_pop;
    logic [63:0] w_addr;

    // address widened to the fixed width carried through the queue
    assign w_addr = 64'(i_rom_address);

    // configuration port always ready, one register per write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time      <= 10'd480;
            r_cfg.reset_release_time  <= 10'd300;
            r_cfg.wait_high_limit     <= 8'd100;
            r_cfg.write_one_low_time  <= 7'd10;
            r_cfg.write_zero_low_time <= 7'd55;
            r_cfg.read_low_time       <= 7'd3;
            r_cfg.read_sample_delay   <= 7'd10;
            r_cfg.slot_time           <= 7'd60;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:     r_cfg.reset_low_time      <= i_cfg_data;
                CFG_RESET_RELEASE: r_cfg.reset_release_time  <= i_cfg_data;
                CFG_WAIT_LIMIT:    r_cfg.wait_high_limit     <= i_cfg_data[7:0];
                CFG_WRITE_ONE:     r_cfg.write_one_low_time  <= i_cfg_data[6:0];
                CFG_WRITE_ZERO:    r_cfg.write_zero_low_time <= i_cfg_data[6:0];
                CFG_READ_LOW:      r_cfg.read_low_time       <= i_cfg_data[6:0];
                CFG_READ_SAMPLE:   r_cfg.read_sample_delay   <= i_cfg_data[6:0];
                CFG_SLOT:          r_cfg.slot_time           <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes requests and marks the ones that start a sequence
    owbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_data_byte   (i_data_byte),
        .i_rom_address (w_addr),
        .i_line_level  (i_line_level),
        .o_push        (w_push),
        .o_item        (w_front_item),
        .i_q_full      (w_q_full)
    );

    // short queue so that front and back stall independently
    owbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // back: sequencer plus result register
    owbm_engine #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive_low   (o_drive_low),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_result (o_read_result),
        .o_timed_out   (o_timed_out),
        .o_rejected    (o_rejected)
    );

endmodule

FILE: rtl/owbm_checker.sv
// owbm_checker: port-level assertions for the one-wire bus master
// depends on nothing; bound to one_wire_bus_master_top

module owbm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_drive_low,
    input logic o_busy_res,
    input logic o_done_res,
    input logic o_timed_out
);

    // a result on offer stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // timeout only comes with completion
    a_tmo_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timed_out |-> o_done_res)
        else $error("timeout without done");

    // a finished sequence is no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done while still busy");

    // bus is never pulled low in the microsecond a reset times out
    a_tmo_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timed_out |-> !o_drive_low)
        else $error("bus driven low on timeout");

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_drive_low (o_drive_low),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_timed_out (o_timed_out)
);
